### rtl/css_pkg.sv
// Package for the command signature screen: verdict codes, signature table and match logic.
`timescale 1ns / 1ps

package css_pkg;

    localparam int WINDOW_BYTES = 16;
    localparam int SIG_BYTES    = WINDOW_BYTES + 1;
    localparam int SIG_W        = 8 * SIG_BYTES;
    localparam int SIG_COUNT    = 39;
    localparam int CNT_W        = 17;

    typedef logic [WINDOW_BYTES-1:0][7:0] window_t;

    typedef enum logic [2:0] {
        VERDICT_OK          = 3'd0,
        VERDICT_BAD_LENGTH  = 3'd1,
        VERDICT_INJECTION   = 3'd2,
        VERDICT_REDIRECT    = 3'd3,
        VERDICT_EXEC        = 3'd4,
        VERDICT_DESTRUCTIVE = 3'd5
    } verdict_t;

    localparam int GRP_INJECTION   = 0;
    localparam int GRP_REDIRECT    = 1;
    localparam int GRP_EXEC        = 2;
    localparam int GRP_DESTRUCTIVE = 3;

    // Last signature byte sits in the low byte of each entry.
    localparam logic [SIG_W-1:0] SIG_TEXT [SIG_COUNT] = '{
        SIG_W'("$("), SIG_W'(8'h60), SIG_W'("${"),
        SIG_W'(">/etc/"), SIG_W'(">>/etc/"), SIG_W'("> /etc/"),
        SIG_W'(">/boot/"), SIG_W'("> /boot/"),
        SIG_W'(">/dev/"), SIG_W'("> /dev/"),
        SIG_W'(">/proc/"), SIG_W'("> /proc/"),
        SIG_W'(">/sys/"), SIG_W'("> /sys/"),
        SIG_W'("eval "), SIG_W'("bash -c"), SIG_W'("sh -c"), SIG_W'("zsh -c"),
        SIG_W'("python -c"), SIG_W'("python3 -c"), SIG_W'("perl -e"),
        SIG_W'("ruby -e"), SIG_W'("node -e"),
        SIG_W'("rm -rf /"), SIG_W'("rm -rf /*"),
        SIG_W'("dd if=/dev/zero"), SIG_W'("dd if=/dev/random"),
        SIG_W'("mkfs"), SIG_W'("mkswap /dev/"),
        SIG_W'(":(){:|:&};:"),
        SIG_W'("chmod -R 777 /"), SIG_W'("chmod 777 /etc"),
        SIG_W'("chown -R"),
        SIG_W'("shred /dev/"), SIG_W'("wipefs"),
        SIG_W'("parted /dev/"), SIG_W'("fdisk /dev/"),
        SIG_W'("> /dev/sda"), SIG_W'("mv /* /dev/null")
    };

    localparam int SIG_LEN [SIG_COUNT] = '{
        2, 1, 2,
        6, 7, 7,
        7, 8,
        6, 7,
        7, 8,
        6, 7,
        5, 7, 5, 6,
        9, 10, 7,
        7, 7,
        8, 9,
        15, 17,
        4, 12,
        11,
        14, 14,
        8,
        11, 6,
        12, 11,
        10, 15
    };

    localparam int SIG_GROUP [SIG_COUNT] = '{
        0, 0, 0,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        2, 2, 2, 2, 2, 2, 2, 2, 2,
        3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3
    };

    // Byte mask covering the given number of low bytes.
    function automatic logic [SIG_W-1:0] sig_mask(input int len);
        logic [SIG_W-1:0] m;
        m = '0;
        for (int k = 0; k < SIG_BYTES; k++)
        begin
            if (k < len)
            begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Groups hit by the new byte together with the window ahead of it.
    function automatic logic [3:0] match_groups(input window_t win, input logic [7:0] b);
        logic [SIG_W-1:0] cand;
        logic [3:0]       hits;
        cand = {win, b};
        hits = '0;
        for (int s = 0; s < SIG_COUNT; s++)
        begin
            if (SIG_LEN[s] <= SIG_BYTES &&
                ((cand ^ SIG_TEXT[s]) & sig_mask(SIG_LEN[s])) == '0)
            begin
                hits[SIG_GROUP[s]] = 1'b1;
            end
        end
        return hits;
    endfunction

endpackage

### rtl/command_signature_screen_core.sv
// Command signature screen: byte-stream shell command screening with one verdict per command.
//
//  channel   | signals                                        | notes
//  char      | char_valid/char_ready, char_byte, carries_byte, | one transaction per byte or
//            | end_of_command                                  | bare end marker
//  verdict   | verdict_valid/verdict_ready, verdict            | one transaction per end item
//  cfg       | cfg_we, cfg_wdata                               | max_length, write only
//
// One item per cycle sustained while no end item is stalled: a char transaction lands in an
// input register, and from there the window compare, hit flags, length count and verdict
// resolve in one pass into the result register. verdict_valid rises once the end item
// leaves the input register and its verdict is registered.
// Reset clears the window, count and hit flags and sets max_length to 1024.
// Only an end item stalls, and only while the verdict register is full and not taken.
`timescale 1ns / 1ps

module command_signature_screen_core
    import css_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_byte,
    input  logic        carries_byte,
    input  logic        end_of_command,
    output logic        verdict_valid,
    input  logic        verdict_ready,
    output logic [2:0]  verdict
);

    logic [15:0]      max_length_reg;
    logic             item_valid_reg;
    logic [7:0]       item_byte_reg;
    logic             item_carries_reg;
    logic             item_end_reg;
    window_t          window_reg, window_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       hits_reg, hits_next;
    logic             out_valid_reg;
    verdict_t         out_verdict_reg, verdict_next;
    logic             advance;

    assign advance    = item_valid_reg && (!item_end_reg || !out_valid_reg || verdict_ready);
    assign char_ready = !item_valid_reg || advance;

    // Fold the current byte into the command state.
    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        hits_next   = hits_reg;
        if (item_carries_reg)
        begin
            hits_next   = hits_reg | match_groups(window_reg, item_byte_reg);
            window_next = {window_reg[WINDOW_BYTES-2:0], item_byte_reg};
            if (!count_reg[CNT_W-1])
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (count_next == '0 || count_next > {1'b0, max_length_reg})
            verdict_next = VERDICT_BAD_LENGTH;
        else if (hits_next[GRP_INJECTION])
            verdict_next = VERDICT_INJECTION;
        else if (hits_next[GRP_REDIRECT])
            verdict_next = VERDICT_REDIRECT;
        else if (hits_next[GRP_EXEC])
            verdict_next = VERDICT_EXEC;
        else if (hits_next[GRP_DESTRUCTIVE])
            verdict_next = VERDICT_DESTRUCTIVE;
        else
            verdict_next = VERDICT_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= 16'd1024;
        end
        else if (cfg_we)
        begin
            max_length_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (char_ready)
        begin
            item_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            item_byte_reg    <= char_byte;
            item_carries_reg <= carries_byte;
            item_end_reg     <= end_of_command;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            hits_reg   <= '0;
        end
        else if (advance)
        begin
            // Clear for the next command once the verdict is out.
            if (item_end_reg)
            begin
                window_reg <= '0;
                count_reg  <= '0;
                hits_reg   <= '0;
            end
            else
            begin
                window_reg <= window_next;
                count_reg  <= count_next;
                hits_reg   <= hits_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && item_end_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_end_reg)
        begin
            out_verdict_reg <= verdict_next;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = out_verdict_reg;

endmodule
